/* sv/hec_pkg.sv */
// shared types and constants for the ftcs heat equation stepper
// no dependencies
`default_nettype none

package hec_pkg;

  // defaults for the top level parameters
  localparam int unsigned MAX_POINTS_DEF    = 64;
  localparam int unsigned SAMPLE_BITS_DEF   = 32;
  localparam int unsigned RATIO_FRAC_DEF    = 16;

  // register file geometry
  localparam int unsigned CFG_INDEX_BITS    = 3;
  localparam int unsigned CFG_DATA_BITS     = 32;
  localparam int unsigned POINT_COUNT_BITS  = 7;
  localparam int unsigned TIME_ROWS_BITS    = 16;
  localparam int unsigned RATIO_BITS        = 16;
  localparam int unsigned TEMP_BITS         = 32;

  // register reset values
  localparam logic [POINT_COUNT_BITS-1:0] POINT_COUNT_RST = 7'd64;
  localparam logic [TIME_ROWS_BITS-1:0]   TIME_ROWS_RST   = 16'd1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_POINT_COUNT  = 3'd0,
    REG_TIME_ROWS    = 3'd1,
    REG_RATIO        = 3'd2,
    REG_DIRICHLET    = 3'd3,
    REG_LEFT_TEMP    = 3'd4,
    REG_RIGHT_TEMP   = 3'd5
  } cfg_reg_e;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_FORCE,
    OP_LAP,
    OP_MULT,
    OP_UPDATE,
    OP_SHIFT
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FORCE,
    ST_LAP,
    ST_MULT,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  // control and status from the sequencer
  typedef struct packed {
    op_e  op;
    logic in_ready;
    logic out_valid;
    logic row_end;
  } hec_ctl_t;

endpackage

`default_nettype wire

/* sv/hec_cell.sv */
// one grid point of the stepper: holds a sample, its laplacian and scaled update
// depends on hec_pkg
`default_nettype none

module hec_cell import hec_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned RATIO_FRACTION_BITS = RATIO_FRAC_DEF
) (
  input  wire                          clk_i,
  input  op_e                          op_i,
  input  wire                          load_sel_i,
  input  wire                          is_end_i,
  input  wire                          interior_i,
  input  wire signed [SAMPLE_BITS-1:0] bound_i,
  input  wire signed [SAMPLE_BITS-1:0] sample_i,
  input  wire        [RATIO_BITS-1:0]  ratio_i,
  input  wire signed [SAMPLE_BITS-1:0] left_i,
  input  wire signed [SAMPLE_BITS-1:0] right_i,
  output logic signed [SAMPLE_BITS-1:0] value_o
);

  localparam int unsigned LW = SAMPLE_BITS + 2;
  localparam int unsigned PW = LW + RATIO_BITS + 1;
  localparam int unsigned SW = PW + 1;
  localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic signed [SAMPLE_BITS-1:0] val_q;
  logic signed [LW-1:0]          lap_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [LW-1:0]          lap_d;
  logic signed [PW-1:0]          prod_d;
  logic signed [SW-1:0]          sum;
  logic signed [SAMPLE_BITS-1:0] upd;

  // second difference against both neighbors
  assign lap_d = LW'(right_i) - (LW'(val_q) <<< 1) + LW'(left_i);

  // ratio times laplacian, ratio taken as unsigned
  assign prod_d = PW'(lap_q) * PW'($signed({1'b0, ratio_i}));

  // floor of the scaled term, add and saturate
  always_comb begin
    sum = SW'(val_q) + SW'(prod_q >>> RATIO_FRACTION_BITS);
    if (sum > SMAX) begin
      upd = SAMPLE_BITS'(SMAX);
    end else if (sum < SMIN) begin
      upd = SAMPLE_BITS'(SMIN);
    end else begin
      upd = SAMPLE_BITS'(sum);
    end
  end

  // sample and pipeline registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        if (load_sel_i) val_q <= sample_i;
      end
      OP_FORCE: begin
        if (is_end_i) val_q <= bound_i;
      end
      OP_LAP: begin
        lap_q <= lap_d;
      end
      OP_MULT: begin
        prod_q <= prod_d;
      end
      OP_UPDATE: begin
        if (interior_i) val_q <= upd;
      end
      OP_SHIFT: begin
        val_q <= right_i;
      end
      default: begin
      end
    endcase
  end

  assign value_o = val_q;

endmodule

`default_nettype wire

/* sv/hec_ctrl.sv */
// sequencer for load, time stepping and emission of the row
// depends on hec_pkg
`default_nettype none

module hec_ctrl import hec_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1),
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  input  wire                         out_stall_i,
  input  wire  [POINT_COUNT_BITS-1:0] point_count_i,
  input  wire  [TIME_ROWS_BITS-1:0]   time_rows_i,
  output hec_ctl_t                    ctl_o,
  output logic [AW-1:0]               load_pos_o,
  output logic [CW-1:0]               row_len_o
);

  state_e                    state_q, state_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [CW-1:0]             len_q, len_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [TIME_ROWS_BITS-1:0] steps_q, steps_d;
  logic [CW-1:0]             n_eff;
  logic [CW:0]               pos_next;
  logic                      load_done;
  logic [TIME_ROWS_BITS-1:0] rows_eff;

  // point count clamped to 1..MAX_POINTS, rows at least one
  always_comb begin
    if (point_count_i == '0) begin
      n_eff = CW'(1);
    end else if (point_count_i > POINT_COUNT_BITS'(MAX_POINTS)) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = CW'(point_count_i);
    end
    rows_eff  = (time_rows_i == '0) ? TIME_ROWS_BITS'(1) : time_rows_i;
    pos_next  = (CW + 1)'(pos_q) + (CW + 1)'(1);
    load_done = pos_next >= (CW + 1)'(n_eff);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pos_q   <= '0;
      len_q   <= CW'(1);
      idx_q   <= '0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      steps_q <= steps_d;
    end
  end

  // next state and cell operation
  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    len_d         = len_q;
    idx_d         = idx_q;
    steps_d       = steps_q;
    ctl_o.op        = OP_HOLD;
    ctl_o.in_ready  = 1'b0;
    ctl_o.out_valid = 1'b0;
    ctl_o.row_end   = 1'b0;
    case (state_q)
      ST_LOAD: begin
        ctl_o.in_ready = 1'b1;
        if (in_valid_i) begin
          ctl_o.op = OP_LOAD;
          if (load_done) begin
            pos_d = '0;
            len_d = n_eff;
            idx_d = '0;
            if (n_eff == CW'(1)) begin
              state_d = ST_EMIT;
            end else begin
              steps_d = rows_eff - TIME_ROWS_BITS'(1);
              state_d = ST_FORCE;
            end
          end else begin
            pos_d = AW'(pos_next);
          end
        end
      end
      ST_FORCE: begin
        ctl_o.op = OP_FORCE;
        state_d  = (steps_q == '0) ? ST_EMIT : ST_LAP;
      end
      ST_LAP: begin
        ctl_o.op = OP_LAP;
        state_d  = ST_MULT;
      end
      ST_MULT: begin
        ctl_o.op = OP_MULT;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl_o.op = OP_UPDATE;
        steps_d  = steps_q - TIME_ROWS_BITS'(1);
        state_d  = (steps_q == TIME_ROWS_BITS'(1)) ? ST_EMIT : ST_LAP;
      end
      ST_EMIT: begin
        ctl_o.out_valid = 1'b1;
        ctl_o.row_end   = (idx_q == len_q - CW'(1));
        if (!out_stall_i) begin
          ctl_o.op = OP_SHIFT;
          if (ctl_o.row_end) begin
            idx_d   = '0;
            state_d = ST_LOAD;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign load_pos_o = pos_q;
  assign row_len_o  = len_q;

endmodule

`default_nettype wire

/* sv/heat_equation_ftcs_stepper_top.sv */
// top level of the explicit 1-d heat equation stepper: registers, cell row, sequencer
// depends on hec_pkg, hec_cell, hec_ctrl
//
//   channel  signals                                        direction
//   input    in_valid_i, in_stall_o, initial_sample_i       request in
//   output   out_valid_o, out_stall_i, final_sample_o,
//            row_end_o                                      request out
//   config   cfg_valid_i, cfg_ready_o, cfg_index_i,
//            cfg_data_i                                     register write in
//
// one sample is loaded per cycle with in_valid_i high; the last sample starts the run
// a run forces the end cells if dirichlet is set, then each time step is lap, multiply and
// update in every cell at once, the update only changing the interior cells
// the final row then leaves through cell 0, one sample per accepted request
// input is stalled from the last sample until the row end is taken
// reset clears control and registers; the sample row needs no clearing
`default_nettype none

module heat_equation_ftcs_stepper_top import hec_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned RATIO_FRACTION_BITS = RATIO_FRAC_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  signed [SAMPLE_BITS-1:0] initial_sample_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] final_sample_o,
  output logic                         row_end_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  wire  [CFG_DATA_BITS-1:0]     cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic [POINT_COUNT_BITS-1:0] point_count_q;
  logic [TIME_ROWS_BITS-1:0]   time_rows_q;
  logic [RATIO_BITS-1:0]       ratio_q;
  logic                        dirichlet_q;
  logic signed [TEMP_BITS-1:0] left_temp_q;
  logic signed [TEMP_BITS-1:0] right_temp_q;

  hec_ctl_t                    ctl;
  logic [AW-1:0]               load_pos;
  logic [CW-1:0]               row_len;
  logic signed [SAMPLE_BITS-1:0] lb;
  logic signed [SAMPLE_BITS-1:0] rb;
  logic signed [SAMPLE_BITS-1:0] val [MAX_POINTS];

  function automatic logic signed [SAMPLE_BITS-1:0] sat_bound(
    input logic signed [TEMP_BITS-1:0] t
  );
    logic signed [63:0] w;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    w  = 64'(t);
    hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (w > hi) begin
      w = hi;
    end else if (w < lo) begin
      w = lo;
    end
    return SAMPLE_BITS'(w);
  endfunction

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= POINT_COUNT_RST;
      time_rows_q   <= TIME_ROWS_RST;
      ratio_q       <= '0;
      dirichlet_q   <= 1'b1;
      left_temp_q   <= '0;
      right_temp_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_POINT_COUNT: point_count_q <= cfg_data_i[POINT_COUNT_BITS-1:0];
        REG_TIME_ROWS:   time_rows_q   <= cfg_data_i[TIME_ROWS_BITS-1:0];
        REG_RATIO:       ratio_q       <= cfg_data_i[RATIO_BITS-1:0];
        REG_DIRICHLET:   dirichlet_q   <= cfg_data_i[0];
        REG_LEFT_TEMP:   left_temp_q   <= $signed(cfg_data_i[TEMP_BITS-1:0]);
        REG_RIGHT_TEMP:  right_temp_q  <= $signed(cfg_data_i[TEMP_BITS-1:0]);
        default: begin
        end
      endcase
    end
  end

  // boundary values clamped to the sample range
  assign lb = sat_bound(left_temp_q);
  assign rb = sat_bound(right_temp_q);

  // sequencer
  hec_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .out_stall_i   (out_stall_i),
    .point_count_i (point_count_q),
    .time_rows_i   (time_rows_q),
    .ctl_o         (ctl),
    .load_pos_o    (load_pos),
    .row_len_o     (row_len)
  );

  // row of cells, each talking to its two neighbors; the outer ends of the array see zero
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left_n;
    logic signed [SAMPLE_BITS-1:0] right_n;
    logic                          is_last;
    logic                          is_end;
    logic                          interior;

    if (i == 0) begin : g_first
      assign left_n = '0;
    end else begin : g_inner_l
      assign left_n = val[i-1];
    end
    if (i == MAX_POINTS - 1) begin : g_last
      assign right_n = '0;
    end else begin : g_inner_r
      assign right_n = val[i+1];
    end

    assign is_last  = (CW'(i) == row_len - CW'(1));
    assign is_end   = dirichlet_q && ((i == 0) || is_last);
    assign interior = (i != 0) && (CW'(i) < row_len - CW'(1));

    hec_cell #(
      .SAMPLE_BITS         (SAMPLE_BITS),
      .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (ctl.op),
      .load_sel_i (load_pos == AW'(i)),
      .is_end_i   (is_end),
      .interior_i (interior),
      .bound_i    ((i == 0) ? lb : rb),
      .sample_i   (initial_sample_i),
      .ratio_i    (ratio_q),
      .left_i     (left_n),
      .right_i    (right_n),
      .value_o    (val[i])
    );
  end

  // handshake and result
  assign in_stall_o     = !ctl.in_ready;
  assign out_valid_o    = ctl.out_valid;
  assign row_end_o      = ctl.row_end;
  assign final_sample_o = val[0];

endmodule

`default_nettype wire

/* sv/hec_checker.sv */
// port-level checks for the heat equation stepper, bound to the top level
// depends on hec_pkg and heat_equation_ftcs_stepper_top
`default_nettype none

module hec_checker import hec_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   in_valid_i,
  input wire                   in_stall_o,
  input wire [SAMPLE_BITS-1:0] final_sample_o,
  input wire                   out_valid_o,
  input wire                   out_stall_i,
  input wire                   row_end_o
);

  // no new request is taken while the row is being emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while results pending");

  // the row ends cleanly after its last sample is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && row_end_o) |=> !out_valid_o)
    else $error("result after row end");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(final_sample_o) && $stable(row_end_o)))
    else $error("stalled result changed");

  // no result is offered in a cycle in which a load request is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !out_valid_o)
    else $error("result while loading");

endmodule

bind heat_equation_ftcs_stepper_top hec_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_hec_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .final_sample_o (final_sample_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .row_end_o      (row_end_o)
);

`default_nettype wire
